>>> src/rtc_cmos_index_data_port_assert.svh
// Assertion macros for the CMOS index/data port block.
// Used by the top level; the macros expect aclk and aresetn in scope.
`ifndef RTC_CMOS_INDEX_DATA_PORT_ASSERT_SVH
`define RTC_CMOS_INDEX_DATA_PORT_ASSERT_SVH
`ifndef SYNTHESIS
`define RTCCMOS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);
`define RTCCMOS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RTCCMOS_ASSERT(label, prop, msg)
`define RTCCMOS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> src/rtccmos_pkg.sv
// Shared types, constants and BCD helper for the CMOS index/data port block.
// No dependencies.
`timescale 1ns / 1ps

package rtccmos_pkg;

    localparam int RAM_BYTES = 64;
    localparam int IDX_W     = $clog2(RAM_BYTES);

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    localparam logic PORT_INDEX = 1'b0;
    localparam logic PORT_DATA  = 1'b1;

    localparam idx_t IDX_SEC      = IDX_W'('h00);
    localparam idx_t IDX_MIN      = IDX_W'('h02);
    localparam idx_t IDX_HOUR     = IDX_W'('h04);
    localparam idx_t IDX_WDAY     = IDX_W'('h06);
    localparam idx_t IDX_MDAY     = IDX_W'('h07);
    localparam idx_t IDX_MON      = IDX_W'('h08);
    localparam idx_t IDX_YEAR     = IDX_W'('h09);
    localparam idx_t IDX_STATUS_A = IDX_W'('h0A);
    localparam idx_t IDX_STATUS_B = IDX_W'('h0B);
    localparam idx_t IDX_DEFAULT  = IDX_W'('h0D);
    localparam idx_t IDX_CENTURY  = IDX_W'('h32);

    localparam logic [6:0] CENTURY  = 7'd20;
    localparam logic [6:0] YEAR_MAX = 7'd99;
    localparam int         BIN_BIT  = 2;

    // Two BCD digits of v: tens wrap modulo ten, divide by ten via 205/2048.
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [3:0]  ones;
        logic [3:0]  tens;
        prod = 15'(v) * 15'd205;
        q    = prod[14:11];
        ones = 4'(v - 7'(q) * 7'd10);
        tens = (q >= 4'd10) ? q - 4'd10 : q;
        return {tens, ones};
    endfunction

endpackage

>>> src/rtc_cmos_index_data_port.sv
// Top level of the CMOS register file behind an index port and a data port.
// Depends on rtccmos_pkg, rtccmos_ram and rtc_cmos_index_data_port_assert.svh.
//
//   channel  | ports                                   | direction
//   ---------+-----------------------------------------+----------
//   s_       | s_valid s_ready s_cmd s_port_sel        | in
//            | s_write_data s_time_*                   |
//   m_       | m_valid m_ready m_read_data             | out
//
// One word is accepted per cycle while s_ready is high; writes and ticks update
// state at acceptance. A read word loads the RAM read register and the s1_ stage
// at acceptance, then the output register once it is free, which raises m_valid.
// Synchronous active-low reset; RAM contents read as zero until written, through
// one valid bit per byte, so there is no clearing pass.
// With m_ready low, one more read is taken into the middle stage, then s_ready drops.
`timescale 1ns / 1ps
`include "rtc_cmos_index_data_port_assert.svh"

module rtc_cmos_index_data_port (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_cmd,
    input  logic       s_port_sel,
    input  logic [7:0] s_write_data,
    input  logic [5:0] s_time_sec,
    input  logic [5:0] s_time_min,
    input  logic [4:0] s_time_hour,
    input  logic [2:0] s_time_wday,
    input  logic [4:0] s_time_mday,
    input  logic [3:0] s_time_mon,
    input  logic [6:0] s_time_year,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data
);

    import rtccmos_pkg::*;

    idx_t                 reg_index_reg, reg_index_next;
    logic                 busy_reg, busy_next;
    logic                 binary_reg, binary_next;
    logic [RAM_BYTES-1:0] ram_valid_reg, ram_valid_next;
    logic [5:0]           cur_sec_reg, cur_sec_next;
    logic [5:0]           cur_min_reg, cur_min_next;
    logic [4:0]           cur_hour_reg, cur_hour_next;
    logic [2:0]           cur_wday_reg, cur_wday_next;
    logic [4:0]           cur_mday_reg, cur_mday_next;
    logic [3:0]           cur_mon_reg, cur_mon_next;
    logic [6:0]           cur_year_reg, cur_year_next;

    logic                 s1_valid_reg, s1_valid_next;
    logic [7:0]           s1_mask_reg, s1_mask_next;
    logic [7:0]           s1_or_reg, s1_or_next;
    logic                 m_valid_reg, m_valid_next;
    logic [7:0]           m_read_data_reg, m_read_data_next;

    logic                 s_accept;
    logic                 out_free;
    logic                 is_read;
    logic                 is_data_read;
    logic                 is_data_write;
    logic                 is_tick;
    logic [7:0]           ram_rd_data;
    logic [6:0]           time_val;
    logic                 time_hit;
    logic [7:0]           time_byte;

    assign out_free      = !m_valid_reg || m_ready;
    assign s_ready       = !s1_valid_reg || out_free;
    assign s_accept      = s_valid && s_ready;
    assign is_read       = s_accept && (s_cmd == CMD_READ);
    assign is_data_read  = is_read && (s_port_sel == PORT_DATA);
    assign is_data_write = s_accept && (s_cmd == CMD_WRITE) && (s_port_sel == PORT_DATA);
    assign is_tick       = s_accept && (s_cmd == CMD_TICK);

    rtccmos_ram #(
        .WIDTH (8),
        .DEPTH (RAM_BYTES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (is_data_write),
        .wr_addr (reg_index_reg),
        .wr_data (s_write_data),
        .rd_en   (is_data_read),
        .rd_addr (reg_index_reg),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        time_hit = 1'b1;
        unique case (reg_index_reg)
            IDX_SEC:     time_val = 7'(cur_sec_reg);
            IDX_MIN:     time_val = 7'(cur_min_reg);
            IDX_HOUR:    time_val = 7'(cur_hour_reg);
            IDX_WDAY:    time_val = 7'(cur_wday_reg) + 7'd1;
            IDX_MDAY:    time_val = 7'(cur_mday_reg);
            IDX_MON:     time_val = 7'(cur_mon_reg) + 7'd1;
            IDX_YEAR:    time_val = cur_year_reg;
            IDX_CENTURY: time_val = CENTURY;
            default: begin
                time_val = '0;
                time_hit = 1'b0;
            end
        endcase
        time_byte = binary_reg ? {1'b0, time_val} : to_bcd(time_val);
    end

    always_comb begin
        logic [7:0] mask;
        reg_index_next = reg_index_reg;
        busy_next      = busy_reg;
        binary_next    = binary_reg;
        ram_valid_next = ram_valid_reg;
        cur_sec_next   = cur_sec_reg;
        cur_min_next   = cur_min_reg;
        cur_hour_next  = cur_hour_reg;
        cur_wday_next  = cur_wday_reg;
        cur_mday_next  = cur_mday_reg;
        cur_mon_next   = cur_mon_reg;
        cur_year_next  = cur_year_reg;
        s1_mask_next   = s1_mask_reg;
        s1_or_next     = s1_or_reg;
        mask           = '0;

        if (s_accept) begin
            unique case (s_cmd)
                CMD_READ: begin
                    if (s_port_sel == PORT_INDEX) begin
                        s1_or_next = 8'(reg_index_reg);
                    end else begin
                        s1_or_next = '0;
                        if (time_hit) begin
                            s1_or_next = time_byte;
                        end else begin
                            unique case (reg_index_reg)
                                IDX_STATUS_A: begin
                                    mask       = 8'h7F;
                                    s1_or_next = {busy_reg, 7'd0};
                                    busy_next  = 1'b0;
                                end
                                IDX_STATUS_B: mask = 8'hFD;
                                IDX_DEFAULT:  s1_or_next = 8'h80;
                                default:      mask = 8'hFF;
                            endcase
                        end
                        reg_index_next = IDX_DEFAULT;
                    end
                    s1_mask_next = ram_valid_reg[reg_index_reg] ? mask : 8'h00;
                end
                CMD_WRITE: begin
                    if (s_port_sel == PORT_INDEX) begin
                        reg_index_next = ({1'b0, s_write_data} >= 9'(RAM_BYTES))
                                       ? IDX_DEFAULT : IDX_W'(s_write_data);
                    end else begin
                        ram_valid_next[reg_index_reg] = 1'b1;
                        if (reg_index_reg == IDX_STATUS_B) begin
                            binary_next = s_write_data[BIN_BIT];
                        end
                        reg_index_next = IDX_DEFAULT;
                    end
                end
                CMD_TICK: begin
                    cur_sec_next  = s_time_sec;
                    cur_min_next  = s_time_min;
                    cur_hour_next = s_time_hour;
                    cur_wday_next = s_time_wday;
                    cur_mday_next = s_time_mday;
                    cur_mon_next  = s_time_mon;
                    cur_year_next = (s_time_year > YEAR_MAX) ? YEAR_MAX : s_time_year;
                    busy_next     = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        s1_valid_next    = s_ready ? is_read : s1_valid_reg;
        m_valid_next     = out_free ? s1_valid_reg : m_valid_reg;
        m_read_data_next = m_read_data_reg;
        if (out_free && s1_valid_reg) begin
            m_read_data_next = (ram_rd_data & s1_mask_reg) | s1_or_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reg_index_reg <= '0;
            busy_reg      <= 1'b0;
            binary_reg    <= 1'b0;
            ram_valid_reg <= '0;
            cur_sec_reg   <= '0;
            cur_min_reg   <= '0;
            cur_hour_reg  <= '0;
            cur_wday_reg  <= '0;
            cur_mday_reg  <= '0;
            cur_mon_reg   <= '0;
            cur_year_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            reg_index_reg <= reg_index_next;
            busy_reg      <= busy_next;
            binary_reg    <= binary_next;
            ram_valid_reg <= ram_valid_next;
            cur_sec_reg   <= cur_sec_next;
            cur_min_reg   <= cur_min_next;
            cur_hour_reg  <= cur_hour_next;
            cur_wday_reg  <= cur_wday_next;
            cur_mday_reg  <= cur_mday_next;
            cur_mon_reg   <= cur_mon_next;
            cur_year_reg  <= cur_year_next;
            s1_valid_reg  <= s1_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_mask_reg     <= s1_mask_next;
        s1_or_reg       <= s1_or_next;
        m_read_data_reg <= m_read_data_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;

    `RTCCMOS_ASSERT_NEXT(a_data_write_idx, is_data_write, reg_index_reg == IDX_DEFAULT, "index not reset after data write")
    `RTCCMOS_ASSERT_NEXT(a_tick_busy, is_tick, busy_reg, "tick did not set busy")
    `RTCCMOS_ASSERT_NEXT(a_status_a_clear, is_data_read && (reg_index_reg == IDX_STATUS_A), !busy_reg, "status A read kept busy")
    `RTCCMOS_ASSERT(a_year_range, cur_year_reg <= YEAR_MAX, "year above 99")
    `RTCCMOS_ASSERT(a_index_range, {1'b0, reg_index_reg} < (IDX_W + 1)'(RAM_BYTES), "index beyond RAM")

endmodule

>>> src/rtccmos_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rtccmos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
